### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. They sample on clk and are disabled
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/jakr_pkg.sv
// ----------------------------------------------------------------------------
// Joystick axis key repeater package
// Shared constants, register indexes and lane result type.
// ----------------------------------------------------------------------------
package jakr_pkg;

  localparam int AXIS_SLOTS   = 2;   // sample fields per item
  localparam int NUM_AXES_DEF = 2;

  localparam int SAMPLE_W = 16;
  localparam int KEY_W    = 32;
  localparam int THR_W    = 16;
  localparam int ACC_W    = 31;
  localparam int CD_W     = 8;
  localparam int AXES_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CD_W-1:0]   REPEAT_DELAY  = 8'd20;
  localparam logic [AXES_W-1:0] AXES_RESET    = 2'd2;
  localparam logic [THR_W-1:0]  THR_RESET     = 16'd100;
  localparam logic [ACC_W-1:0]  ACC_MAX       = {ACC_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_AXES   = 3'd0,
    REG_REPEAT_THR    = 3'd1,
    REG_UP_KEY_X      = 3'd2,
    REG_UP_KEY_Y      = 3'd3,
    REG_DOWN_OFFSET_X = 3'd4,
    REG_DOWN_OFFSET_Y = 3'd5
  } cfg_reg_t;

  // What one lane found for the current item.
  typedef struct packed {
    logic             tap;
    logic [KEY_W-1:0] key;
  } lane_res_t;

endpackage

### hw/rtl/jakr_lane.sv
// ----------------------------------------------------------------------------
// Axis lane
// Holds one axis's key state and decides, for each accepted item, whether the
// axis taps a key and which one.
// ----------------------------------------------------------------------------
module jakr_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  logic                           active,
  input  logic signed [jakr_pkg::SAMPLE_W-1:0] sample,
  input  logic                           read_error,
  input  logic [jakr_pkg::KEY_W-1:0]     up_key,
  input  logic [jakr_pkg::KEY_W-1:0]     dn_key,
  input  logic [jakr_pkg::THR_W-1:0]     thr,
  output jakr_pkg::lane_res_t            res
);
  import jakr_pkg::*;

  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [CD_W-1:0]     cd_r, cd_nxt;
  logic [KEY_W-1:0]    held_key_r, held_key_nxt;
  logic                held_valid_r, held_valid_nxt;

  logic [SAMPLE_W-1:0] raw;
  logic [SAMPLE_W-1:0] mag;
  logic                is_zero;
  logic                neg;
  logic [KEY_W-1:0]    key;
  logic                same;
  logic [ACC_W:0]      sum;
  logic [ACC_W-1:0]    sat;
  logic [ACC_W-1:0]    thr_ext;
  logic                reach;
  logic                tap;

  always_comb begin
    raw     = read_error ? '0 : sample;
    is_zero = (raw == '0);
    neg     = raw[SAMPLE_W-1];
    mag     = neg ? SAMPLE_W'(SAMPLE_W'(0) - raw) : raw;
    key     = neg ? up_key : dn_key;
    same    = held_valid_r && (held_key_r == key);
    sum     = {1'b0, acc_r} + (ACC_W+1)'(mag);
    sat     = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    thr_ext = ACC_W'(thr);
    reach   = (sat >= thr_ext);
    // A new key always taps; a held key taps only after the delay has run out.
    tap     = active && !is_zero && (!same || ((cd_r == '0) && reach));
  end

  always_comb begin
    acc_nxt        = acc_r;
    cd_nxt         = cd_r;
    held_key_nxt   = held_key_r;
    held_valid_nxt = held_valid_r;
    if (fire && active) begin
      if (is_zero) begin
        held_valid_nxt = 1'b0;
        cd_nxt         = '0;
      end else if (!same) begin
        // Loaded with the threshold and tapped at once, which leaves zero.
        acc_nxt        = '0;
        held_key_nxt   = key;
        held_valid_nxt = 1'b1;
        cd_nxt         = REPEAT_DELAY;
      end else if (cd_r != '0) begin
        cd_nxt = cd_r - CD_W'(1);
      end else begin
        acc_nxt = reach ? (sat - thr_ext) : sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      cd_r         <= '0;
      held_key_r   <= '0;
      held_valid_r <= 1'b0;
    end else begin
      acc_r        <= acc_nxt;
      cd_r         <= cd_nxt;
      held_key_r   <= held_key_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  assign res.tap = tap;
  assign res.key = key;

endmodule

### hw/rtl/jakr_merge.sv
// ----------------------------------------------------------------------------
// Tap merger
// Collects the lanes' taps for one item and sends each as a press and then a
// release through a registered output, lowest lane first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jakr_merge #(
  parameter int LANES = jakr_pkg::NUM_AXES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_fire,
  output logic                        in_ready,
  input  jakr_pkg::lane_res_t         lane_res [LANES],
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [jakr_pkg::KEY_W-1:0]  out_key_code,
  output logic                        out_pressed,
  output logic                        out_last_of_run
);
  import jakr_pkg::*;

  logic [LANES-1:0] mask_r, mask_nxt;
  logic [KEY_W-1:0] key_r [LANES];
  logic             phase_r, phase_nxt;   // 1 while the release is due
  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic             out_pressed_r;
  logic             out_last_r;

  logic [LANES-1:0] taps;
  logic [LANES-1:0] sel_oh;
  logic [LANES-1:0] remaining;
  logic [KEY_W-1:0] sel_key;
  logic             adv;
  logic             emit;
  logic             last_going;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      taps[i] = lane_res[i].tap;
    end
    sel_oh    = mask_r & ~(mask_r - LANES'(1));
    remaining = mask_r & ~sel_oh;
    sel_key   = '0;
    for (int i = 0; i < LANES; i++) begin
      sel_key = sel_key | (sel_oh[i] ? key_r[i] : '0);
    end
    adv        = !out_valid_r || out_ready;
    emit       = adv && (mask_r != '0);
    last_going = emit && phase_r && (remaining == '0);
    in_ready   = (mask_r == '0) || last_going;
  end

  always_comb begin
    mask_nxt  = mask_r;
    phase_nxt = phase_r;
    if (in_fire) begin
      mask_nxt  = taps;
      phase_nxt = 1'b0;
    end else if (emit) begin
      if (phase_r) begin
        mask_nxt = remaining;
      end
      phase_nxt = !phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r  <= mask_nxt;
      phase_r <= phase_nxt;
      if (adv) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < LANES; i++) begin
        key_r[i] <= lane_res[i].key;
      end
    end
    if (emit) begin
      out_key_r     <= sel_key;
      out_pressed_r <= !phase_r;
      out_last_r    <= phase_r && (remaining == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_code    = out_key_r;
  assign out_pressed     = out_pressed_r;
  assign out_last_of_run = out_last_r;

  `AST_IMP(a_press_not_last, out_valid && out_pressed, !out_last_of_run,
           "a press was marked as the last item of a run")
  `AST_NXT(a_quiet_item_clears, in_fire && (taps == '0), mask_r == '0,
           "an item without taps left taps pending")
  `AST_IMP(a_release_has_tap, phase_r, mask_r != '0,
           "release phase without a pending tap")

endmodule

### hw/rtl/joystick_axis_key_repeater_top.sv
// ----------------------------------------------------------------------------
// Joystick axis key repeater, top level
// One lane per axis turns the tick's samples into key taps; the merger sends
// them out as press and release items.
// ----------------------------------------------------------------------------
// An item that causes no tap is taken at once, and the input stays ready for
// the next item. Every tap becomes two result items, a press and a release,
// which leave one per cycle while the output side does not stall, through a
// single output register, so an item with k taps yields 2k result items. The
// input is ready again in the cycle that the last release of the previous item
// moves into the output register. Configuration writes take effect at the
// write edge.
module joystick_axis_key_repeater_top #(
  parameter int NUM_AXES = jakr_pkg::NUM_AXES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [jakr_pkg::SAMPLE_W-1:0] in_sample_x,
  input  logic signed [jakr_pkg::SAMPLE_W-1:0] in_sample_y,
  input  logic                               in_read_error_x,
  input  logic                               in_read_error_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [jakr_pkg::KEY_W-1:0]         out_key_code,
  output logic                               out_pressed,
  output logic                               out_last_of_run,
  input  logic                               cfg_we,
  input  logic [jakr_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [jakr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import jakr_pkg::*;

  localparam int LANES = (NUM_AXES < AXIS_SLOTS) ? NUM_AXES : AXIS_SLOTS;

  logic [AXES_W-1:0] active_axes_r;
  logic [THR_W-1:0]  thr_r;
  logic [KEY_W-1:0]  up_key_r [AXIS_SLOTS];
  logic [KEY_W-1:0]  offset_r [AXIS_SLOTS];
  logic [KEY_W-1:0]  dn_key_r [AXIS_SLOTS];   // up key plus offset, kept current

  logic signed [SAMPLE_W-1:0] sample [AXIS_SLOTS];
  logic                       err    [AXIS_SLOTS];
  lane_res_t                  lane_res [LANES];
  logic                       fire;

  assign sample[0] = in_sample_x;
  assign sample[1] = in_sample_y;
  assign err[0]    = in_read_error_x;
  assign err[1]    = in_read_error_y;
  assign fire      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_axes_r <= AXES_RESET;
      thr_r         <= THR_RESET;
      for (int i = 0; i < AXIS_SLOTS; i++) begin
        up_key_r[i] <= '0;
        offset_r[i] <= '0;
        dn_key_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ACTIVE_AXES: active_axes_r <= cfg_wdata[AXES_W-1:0];
        REG_REPEAT_THR:  thr_r         <= cfg_wdata[THR_W-1:0];
        REG_UP_KEY_X: begin
          up_key_r[0] <= cfg_wdata;
          dn_key_r[0] <= cfg_wdata + offset_r[0];
        end
        REG_UP_KEY_Y: begin
          up_key_r[1] <= cfg_wdata;
          dn_key_r[1] <= cfg_wdata + offset_r[1];
        end
        REG_DOWN_OFFSET_X: begin
          offset_r[0] <= cfg_wdata;
          dn_key_r[0] <= up_key_r[0] + cfg_wdata;
        end
        REG_DOWN_OFFSET_Y: begin
          offset_r[1] <= cfg_wdata;
          dn_key_r[1] <= up_key_r[1] + cfg_wdata;
        end
        default: ;
      endcase
    end
  end

  for (genvar a = 0; a < LANES; a++) begin : g_lane
    jakr_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .fire       (fire),
      .active     (active_axes_r > AXES_W'(a)),
      .sample     (sample[a]),
      .read_error (err[a]),
      .up_key     (up_key_r[a]),
      .dn_key     (dn_key_r[a]),
      .thr        (thr_r),
      .res        (lane_res[a])
    );
  end

  jakr_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_fire         (fire),
    .in_ready        (in_ready),
    .lane_res        (lane_res),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_key_code    (out_key_code),
    .out_pressed     (out_pressed),
    .out_last_of_run (out_last_of_run)
  );

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Joystick axis key repeater testbench
// Drives ticks of axis samples into the repeater and checks every key event
// against a cycle-free model of the per-axis hold, repeat delay and
// accumulator. Directed ticks cover field extremes, key wrap and axis counts;
// random gestures under varying back-pressure cover repeats, and a held stick
// with a zero threshold and then a full-scale threshold covers the repeat path.
// ----------------------------------------------------------------------------
module tb_top;
  import jakr_pkg::*;

  localparam int LANES         = NUM_AXES_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int LONG_STALL    = 400;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int RANDOM_TICKS  = 120;
  localparam int HOLD_TICKS    = 40;

  // Indexes the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum int {STICK_CENTER, STICK_NEG, STICK_POS} stick_dir_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             pressed;
    logic             last_of_run;
  } key_event_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_x = '0;
  logic signed [SAMPLE_W-1:0] in_sample_y = '0;
  logic in_read_error_x = 1'b0;
  logic in_read_error_y = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KEY_W-1:0] out_key_code;
  logic out_pressed;
  logic out_last_of_run;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic stall_req = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int ticks_taken = 0;
  int events_checked = 0;
  int reg_writes = 0;

  // Model copy of the registers and of the per-axis state.
  logic [AXES_W-1:0] cfg_axes;
  logic [THR_W-1:0]  cfg_thr;
  logic [KEY_W-1:0]  cfg_up_key [LANES];
  logic [KEY_W-1:0]  cfg_down_off [LANES];
  logic [31:0]       axis_acc [LANES];
  logic [CD_W-1:0]   axis_countdown [LANES];
  logic [KEY_W-1:0]  axis_key [LANES];
  logic              axis_held [LANES];

  key_event_t pending_events[$];

  joystick_axis_key_repeater_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample_x(in_sample_x),
    .in_sample_y(in_sample_y),
    .in_read_error_x(in_read_error_x),
    .in_read_error_y(in_read_error_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_key_code(out_key_code),
    .out_pressed(out_pressed),
    .out_last_of_run(out_last_of_run),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Works out the key events that one accepted tick must produce.
  function automatic void predict_key_events(input logic [SAMPLE_W-1:0] smp_x,
                                             input logic [SAMPLE_W-1:0] smp_y,
                                             input logic err_x, input logic err_y);
    key_event_t ev;
    logic [SAMPLE_W-1:0] raw;
    logic [KEY_W-1:0] key;
    logic [31:0] mag;
    logic [31:0] acc_limit;
    logic [31:0] thr;
    int n_axes;
    int first;
    acc_limit = {1'b0, ACC_MAX};
    thr = {16'd0, cfg_thr};
    first = pending_events.size();
    n_axes = int'(cfg_axes);
    if (n_axes > LANES) n_axes = LANES;
    if (n_axes > AXIS_SLOTS) n_axes = AXIS_SLOTS;
    for (int a = 0; a < n_axes; a++) begin
      raw = (a == 0) ? smp_x : smp_y;
      if ((a == 0) ? err_x : err_y) raw = '0;
      if (raw == '0) begin
        axis_held[a] = 1'b0;
        axis_countdown[a] = '0;
        continue;
      end
      mag = raw[SAMPLE_W-1] ? (32'h10000 - {16'd0, raw}) : {16'd0, raw};
      key = raw[SAMPLE_W-1] ? cfg_up_key[a] : cfg_up_key[a] + cfg_down_off[a];
      if (axis_held[a] && axis_key[a] == key) begin
        if (axis_countdown[a] != '0) begin
          axis_countdown[a] = axis_countdown[a] - 1'b1;
          continue;
        end
        if (axis_acc[a] > acc_limit - mag) axis_acc[a] = acc_limit;
        else axis_acc[a] = axis_acc[a] + mag;
      end else begin
        axis_acc[a] = thr;
        axis_key[a] = key;
        axis_held[a] = 1'b1;
        axis_countdown[a] = REPEAT_DELAY;
      end
      if (axis_acc[a] >= thr) begin
        axis_acc[a] = axis_acc[a] - thr;
        pending_events.push_back('{key: key, pressed: 1'b1, last_of_run: 1'b0});
        pending_events.push_back('{key: key, pressed: 1'b0, last_of_run: 1'b0});
      end
    end
    if (pending_events.size() > first) begin
      ev = pending_events.pop_back();
      ev.last_of_run = 1'b1;
      pending_events.push_back(ev);
    end
  endfunction

  // Checks results, then predicts from accepted ticks and register writes, all
  // from values sampled at the same edge.
  always @(posedge clk) begin
    key_event_t want;
    if (!rst_n) begin
      cfg_axes = AXES_RESET;
      cfg_thr = THR_RESET;
      for (int a = 0; a < LANES; a++) begin
        cfg_up_key[a] = '0;
        cfg_down_off[a] = '0;
        axis_acc[a] = '0;
        axis_countdown[a] = '0;
        axis_key[a] = '0;
        axis_held[a] = 1'b0;
      end
    end else begin
      if (out_valid && out_ready) begin
        events_checked++;
        if (pending_events.size() == 0) begin
          note_failure($sformatf("unexpected key event: key %h pressed %b last %b",
                                 out_key_code, out_pressed, out_last_of_run));
        end else begin
          want = pending_events.pop_front();
          if (out_key_code !== want.key)
            note_failure($sformatf("event %0d key_code: expected %h got %h",
                                   events_checked, want.key, out_key_code));
          if (out_pressed !== want.pressed)
            note_failure($sformatf("event %0d pressed: expected %b got %b",
                                   events_checked, want.pressed, out_pressed));
          if (out_last_of_run !== want.last_of_run)
            note_failure($sformatf("event %0d last_of_run: expected %b got %b",
                                   events_checked, want.last_of_run, out_last_of_run));
        end
      end
      if (in_valid && in_ready) begin
        ticks_taken++;
        predict_key_events(in_sample_x, in_sample_y, in_read_error_x, in_read_error_y);
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_ACTIVE_AXES:   cfg_axes = cfg_wdata[AXES_W-1:0];
          REG_REPEAT_THR:    cfg_thr = cfg_wdata[THR_W-1:0];
          REG_UP_KEY_X:      cfg_up_key[0] = cfg_wdata;
          REG_UP_KEY_Y:      cfg_up_key[1] = cfg_wdata;
          REG_DOWN_OFFSET_X: cfg_down_off[0] = cfg_wdata;
          REG_DOWN_OFFSET_Y: cfg_down_off[1] = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Result side: random back-pressure plus an occasional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_req) begin
        stall_left = LONG_STALL;
        stall_req = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_tick(input logic [SAMPLE_W-1:0] smp_x, input logic [SAMPLE_W-1:0] smp_y,
                           input logic err_x, input logic err_y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_x <= smp_x;
    in_sample_y <= smp_y;
    in_read_error_x <= err_x;
    in_read_error_y <= err_y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering ticks and waits until every predicted event has been seen.
  task automatic wait_drained();
    key_event_t lost;
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    while (pending_events.size() != 0) begin
      lost = pending_events.pop_front();
      note_failure($sformatf("missing key event: key %h pressed %b last %b",
                             lost.key, lost.pressed, lost.last_of_run));
    end
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input stick_dir_t dir);
    int mag;
    mag = 0;
    if (dir == STICK_CENTER) return '0;
    if ($urandom_range(1) == 1) mag = $urandom_range(1, 300);
    else mag = $urandom_range(1, (dir == STICK_NEG) ? 32768 : 32767);
    if (dir == STICK_NEG) return SAMPLE_W'(-mag);
    return SAMPLE_W'(mag);
  endfunction

  task automatic test_reset_defaults();
    send_tick(-16'sd1, 16'sd0, 1'b0, 1'b0);
    send_tick(-16'sd1, 16'sd1, 1'b0, 1'b0);
    send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_sample_extremes();
    write_reg(REG_UP_KEY_X, 32'h0000_0010);
    write_reg(REG_DOWN_OFFSET_X, 32'h7FFF_FFFF);
    write_reg(REG_UP_KEY_Y, 32'hFFFF_FFFF);
    write_reg(REG_DOWN_OFFSET_Y, 32'h8000_0000);
    send_tick(16'sh8000, 16'sd32767, 1'b0, 1'b0);
    send_tick(16'sd32767, 16'sh8000, 1'b0, 1'b0);
    send_tick(16'sd1, -16'sd1, 1'b0, 1'b0);
    // Failed reads count as a centered stick even with a deflection present.
    send_tick(-16'sd1, 16'sd1, 1'b1, 1'b1);
    send_tick(16'sd5, -16'sd5, 1'b1, 1'b0);
    send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_key_wrap();
    write_reg(REG_UP_KEY_X, 32'hFFFF_FFFF);
    write_reg(REG_DOWN_OFFSET_X, 32'h0000_0001);
    write_reg(REG_UP_KEY_Y, 32'h8000_0000);
    write_reg(REG_DOWN_OFFSET_Y, 32'h8000_0000);
    send_tick(16'sd3, 16'sd3, 1'b0, 1'b0);
    send_tick(-16'sd3, -16'sd3, 1'b0, 1'b0);
    send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_axis_count();
    write_reg(REG_ACTIVE_AXES, 32'd0);
    send_tick(16'sd100, -16'sd100, 1'b0, 1'b0);
    wait_drained();
    // Writes to undecoded indexes must leave every register alone.
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
    write_reg(REG_ACTIVE_AXES, 32'd1);
    send_tick(-16'sd7, 16'sd9, 1'b0, 1'b0);
    wait_drained();
    write_reg(REG_ACTIVE_AXES, 32'hFFFF_FFFF);
    send_tick(16'sd7, -16'sd9, 1'b0, 1'b0);
    send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic setup_random_keys(input logic [CFG_DATA_W-1:0] axes,
                                   input logic [CFG_DATA_W-1:0] thr,
                                   input bit zero_offset_x);
    write_reg(REG_ACTIVE_AXES, axes);
    write_reg(REG_REPEAT_THR, thr);
    write_reg(REG_UP_KEY_X, $urandom);
    write_reg(REG_UP_KEY_Y, $urandom);
    // A zero offset makes both directions share one key.
    write_reg(REG_DOWN_OFFSET_X, zero_offset_x ? 32'd0 : $urandom);
    write_reg(REG_DOWN_OFFSET_Y, $urandom);
  endtask

  // Mostly held gestures with jittered magnitude, plus read errors and noise.
  task automatic run_random_gestures(input int n_ticks, input bit with_pressure);
    stick_dir_t dir [LANES];
    int left [LANES];
    logic [SAMPLE_W-1:0] smp [LANES];
    logic err [LANES];
    for (int a = 0; a < LANES; a++) begin
      dir[a] = STICK_CENTER;
      left[a] = 0;
    end
    for (int i = 0; i < n_ticks; i++) begin
      if (with_pressure && i == n_ticks / 3) begin
        in_valid <= 1'b0;
        @(negedge clk) stall_req = 1'b1;
        @(posedge clk);
      end
      if (with_pressure && i == 2 * n_ticks / 3) wait_drained();
      for (int a = 0; a < LANES; a++) begin
        if (left[a] == 0) begin
          if ($urandom_range(99) < 15) dir[a] = STICK_CENTER;
          else dir[a] = stick_dir_t'($urandom_range(1, 2));
          left[a] = $urandom_range(1, 45);
        end
        left[a]--;
        err[a] = ($urandom_range(99) < 5);
        if ($urandom_range(99) < 8) smp[a] = SAMPLE_W'($urandom_range(0, 65535));
        else smp[a] = pick_sample(dir[a]);
      end
      send_tick(smp[0], smp[1], err[0], err[1]);
    end
    wait_drained();
  endtask

  task automatic test_random_sender_slow();
    send_idle_pct = 21;
    recv_idle_pct = 51;
    setup_random_keys(32'd2, 32'd0, 1'b0);
    run_random_gestures(RANDOM_TICKS, 1'b1);
  endtask

  task automatic test_random_receiver_slow();
    send_idle_pct = 51;
    recv_idle_pct = 21;
    setup_random_keys(32'd1, 32'd65535, 1'b0);
    run_random_gestures(RANDOM_TICKS / 2, 1'b0);
    setup_random_keys(32'd2, 32'd65535, 1'b0);
    run_random_gestures(RANDOM_TICKS / 2, 1'b0);
  endtask

  task automatic test_random_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    setup_random_keys(32'd3, $urandom_range(1, 4000), 1'b1);
    run_random_gestures(RANDOM_TICKS, 1'b0);
  endtask

  // With a zero threshold every held tick taps once the delay has run out and
  // the accumulator only grows; a full-scale threshold then draws it down again.
  task automatic test_zero_threshold_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_ACTIVE_AXES, 32'd1);
    write_reg(REG_REPEAT_THR, 32'd0);
    write_reg(REG_UP_KEY_X, 32'h5A5A_0001);
    for (int i = 0; i < HOLD_TICKS; i++) send_tick(16'sh8000, 16'sd0, 1'b0, 1'b0);
    wait_drained();
    write_reg(REG_REPEAT_THR, 32'd65535);
    for (int i = 0; i < 4; i++) send_tick(16'sh8000, 16'sd0, 1'b0, 1'b0);
    send_tick(16'sd0, 16'sd0, 1'b0, 1'b0);
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_sample_extremes();
    test_key_wrap();
    test_axis_count();
    test_random_sender_slow();
    test_random_receiver_slow();
    test_random_full_rate();
    test_zero_threshold_hold();
    $display("Run covered %0d ticks and %0d key events with %0d register writes.",
             ticks_taken, events_checked, reg_writes);
    $display("It spanned axis counts 0 to 3, thresholds 0 to 65535, a long output stall,");
    $display("and a full-scale hold that repeats on every tick.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/jakr_pkg.sv
hw/rtl/jakr_lane.sv
hw/rtl/jakr_merge.sv
hw/rtl/joystick_axis_key_repeater_top.sv
verif/tb_top.sv
